// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the Mandelbrot escape-time block
// Holds field widths, reset values, register and end-cause codes, and the
// work item that travels from the classifier to the iteration engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int MBE_FRAC_BITS   = 28;    // fraction bits of the Q4.28 inputs
   localparam int MBE_QUEUE_DEPTH = 2;     // items between classifier and engine
   localparam int MBE_IN_W        = 32;    // width of one coordinate
   localparam int MBE_CNT_W       = 16;    // width of the iteration count
   localparam int MBE_CAUSE_W     = 2;
   localparam int MBE_ADDR_W      = 3;     // two 32-bit registers
   localparam int MBE_DATA_W      = 32;

   localparam logic [MBE_CNT_W-1:0] MBE_LIMIT_RESET = 16'd1000;
   localparam logic                 MBE_CHECK_RESET = 1'b1;

   // Orbit snapshot interval: starts here and doubles while below the cap.
   localparam int MBE_CHECK_START = 20;
   localparam int MBE_CHECK_CAP   = 1024;

   typedef enum logic [0:0] {
      REG_LIMIT = 1'b0,
      REG_CHECK = 1'b1
   } mbe_reg_type;

   typedef enum logic [MBE_CAUSE_W-1:0] {
      CAUSE_ESCAPED  = 2'd0,
      CAUSE_LIMIT    = 2'd1,
      CAUSE_INTERIOR = 2'd2,
      CAUSE_PERIODIC = 2'd3
   } mbe_cause_type;

   // One classified point waiting for the iteration engine.
   typedef struct packed {
      logic signed [MBE_IN_W-1:0] point_real;
      logic signed [MBE_IN_W-1:0] point_imag;
      logic                       interior;
   } mbe_item_type;

   // Fill status of the hand-off queue.
   typedef struct packed {
      logic full;
      logic empty;
   } mbe_qstat_type;

endpackage

// ----- rtl/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// A point in a known interior region is answered without iterating; any other
// point is iterated until it escapes, reaches the limit or repeats. The front
// end takes a new point once the last one is in the queue, so it works ahead
// while the engine iterates; a full queue holds it back.
// Reset is synchronous; it empties the queue and restores the registers.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: Mandelbrot escape-time unit
// Top level with the register port, the classifier front end, the hand-off
// queue and the iteration engine.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; #(
   parameter int FRAC_BITS   = MBE_FRAC_BITS,     // 20 to 28
   parameter int QUEUE_DEPTH = MBE_QUEUE_DEPTH    // at least 2
) (
   input  logic                       clock,
   input  logic                       reset,

   // Command channel: a beat is taken when start is high and busy is low.
   input  logic                       start,
   output logic                       busy,
   input  logic signed [MBE_IN_W-1:0] req_point_real,
   input  logic signed [MBE_IN_W-1:0] req_point_imag,

   // Result channel: one beat per point, strobed for a single cycle.
   output logic                       rsp_valid,
   output logic [MBE_CNT_W-1:0]       rsp_iteration_count,
   output logic [MBE_CAUSE_W-1:0]     rsp_end_cause,

   // Register port.
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [MBE_ADDR_W-1:0]      paddr,
   input  logic [MBE_DATA_W-1:0]      pwdata,
   output logic [MBE_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // Register file. The limit is held at 16 bits; the periodicity enable is
   // the low bit of its word. Registers sit on word addresses, so bit 2 of
   // the address picks one of them.
   logic [MBE_CNT_W-1:0] limit_ff, limit_in;
   logic                 check_ff, check_in;
   logic                 csr_write;
   mbe_reg_type          csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = mbe_reg_type'(paddr[2]);

   always_comb begin
      limit_in = limit_ff;
      check_in = check_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_LIMIT: limit_in = pwdata[MBE_CNT_W-1:0];
            REG_CHECK: check_in = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_LIMIT: prdata = {{(MBE_DATA_W-MBE_CNT_W){1'b0}}, limit_ff};
         REG_CHECK: prdata = {{(MBE_DATA_W-1){1'b0}}, check_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MBE_LIMIT_RESET;
         check_ff <= MBE_CHECK_RESET;
      end else begin
         limit_ff <= limit_in;
         check_ff <= check_in;
      end
   end

   // The front end takes one point at a time and tags whether it lies in the main
   // cardioid or period-2 bulb. It is free again as soon as the tagged point
   // is in the queue, so it works ahead while the engine iterates.
   mbe_item_type  push_item, head_item;
   mbe_qstat_type q_stat;
   logic          q_push, q_pop;

   mbe_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .point_real (req_point_real),
      .point_imag (req_point_imag),
      .busy       (busy),
      .q_push     (q_push),
      .q_item     (push_item),
      .q_stat     (q_stat)
   );

   mbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   // The engine answers tagged points at once and iterates the others. All
   // results leave from here, so they keep the order in which points came in.
   mbe_iter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_iter (
      .clock               (clock),
      .reset               (reset),
      .q_item              (head_item),
      .q_stat              (q_stat),
      .q_pop               (q_pop),
      .iteration_limit     (limit_ff),
      .cycle_check_enable  (check_ff),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_end_cause       (rsp_end_cause)
   );

endmodule

// ----- rtl/mbe_front.sv -----
// ----------------------------------------------------------------------------
// mbe_front: point intake and interior classifier
// Accepts one point, runs the main cardioid and period-2 bulb tests in the
// SQ, Q and MUL states and pushes the tagged point into the hand-off queue.
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; #(
   parameter int FRAC_BITS = MBE_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [MBE_IN_W-1:0] point_real,
   input  logic signed [MBE_IN_W-1:0] point_imag,
   output logic                       busy,
   output logic                       q_push,
   output mbe_item_type               q_item,
   input  mbe_qstat_type              q_stat
);

   localparam int XW = FRAC_BITS + 3;   // x = cr - 1/4 and bx = cr + 1 inside the box
   localparam int CW = FRAC_BITS + 2;   // ci inside the box
   localparam int SW = 2 * XW;          // squares and their sums
   localparam int QW = FRAC_BITS + 4;   // q and q + x
   localparam int LW = 2 * QW;          // q * (q + x)
   localparam int EW = MBE_IN_W + 1;

   localparam logic signed [EW-1:0] C_ONE     = EW'(1) <<< FRAC_BITS;
   localparam logic signed [EW-1:0] C_TWO     = EW'(2) <<< FRAC_BITS;
   localparam logic signed [EW-1:0] C_QUARTER = EW'(1) <<< (FRAC_BITS - 2);
   localparam logic [SW-1:0]        C_BULB    = SW'(1) << (2 * FRAC_BITS - 4);

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_SQ   = 5'b00010,
      F_Q    = 5'b00100,
      F_MUL  = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   front_state_type          state_ff, state_in;
   logic signed [MBE_IN_W-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic                     box_ff, box_in;
   logic signed [XW-1:0]     x_ff, x_in;
   logic signed [SW-1:0]     xx_ff, xx_in, bxx_ff, bxx_in;
   logic signed [2*CW-1:0]   y2_ff, y2_in;
   logic signed [QW-1:0]     q_ff, q_in, s_ff, s_in;
   logic                     bulb_ff, bulb_in;
   logic signed [LW-1:0]     lhs_ff, lhs_in;

   logic signed [EW-1:0]     cr_ext, ci_ext, x_ext, bx_ext;
   logic signed [XW-1:0]     x_op, bx_op;
   logic signed [CW-1:0]     ci_op;
   logic [SW-1:0]            q_sum;
   logic                     cardioid;

   assign cr_ext = {cr_ff[MBE_IN_W-1], cr_ff};
   assign ci_ext = {ci_ff[MBE_IN_W-1], ci_ff};
   assign x_ext  = cr_ext - C_QUARTER;
   assign bx_ext = cr_ext + C_ONE;
   // Inside the box these truncations keep the values exactly; outside it
   // the region results are discarded.
   assign x_op   = x_ext[XW-1:0];
   assign bx_op  = bx_ext[XW-1:0];
   assign ci_op  = ci_ext[CW-1:0];

   assign q_sum    = $unsigned(xx_ff) + SW'($unsigned(y2_ff));
   assign cardioid = lhs_ff <= $signed({{(LW - 2*CW + 2){1'b0}}, y2_ff[2*CW-1:2]});

   assign busy          = (state_ff != F_IDLE);
   assign q_item.point_real = cr_ff;
   assign q_item.point_imag = ci_ff;
   assign q_item.interior   = box_ff && (cardioid || bulb_ff);

   always_comb begin
      state_in = state_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      box_in   = box_ff;
      x_in     = x_ff;
      xx_in    = xx_ff;
      bxx_in   = bxx_ff;
      y2_in    = y2_ff;
      q_in     = q_ff;
      s_in     = s_ff;
      bulb_in  = bulb_ff;
      lhs_in   = lhs_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               cr_in    = point_real;
               ci_in    = point_imag;
               state_in = F_SQ;
            end
         end
         F_SQ: begin
            box_in   = (cr_ext >= -C_TWO) && (cr_ext <= C_ONE) &&
                       (ci_ext <= C_ONE) && (ci_ext >= -C_ONE);
            x_in     = x_op;
            xx_in    = x_op * x_op;
            bxx_in   = bx_op * bx_op;
            y2_in    = ci_op * ci_op;
            state_in = F_Q;
         end
         F_Q: begin
            q_in     = $signed(q_sum[FRAC_BITS+QW-1:FRAC_BITS]);
            s_in     = $signed(q_sum[FRAC_BITS+QW-1:FRAC_BITS]) +
                       {{(QW-XW){x_ff[XW-1]}}, x_ff};
            bulb_in  = ($unsigned(bxx_ff) + SW'($unsigned(y2_ff))) <= C_BULB;
            state_in = F_MUL;
         end
         F_MUL: begin
            lhs_in   = q_ff * s_ff;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            // Hold the classified point until the queue has room.
            if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      box_ff  <= box_in;
      x_ff    <= x_in;
      xx_ff   <= xx_in;
      bxx_ff  <= bxx_in;
      y2_ff   <= y2_in;
      q_ff    <= q_in;
      s_ff    <= s_in;
      bulb_ff <= bulb_in;
      lhs_ff  <= lhs_in;
   end

endmodule

// ----- rtl/mbe_queue.sv -----
// ----------------------------------------------------------------------------
// mbe_queue: hand-off queue between classifier and iteration engine
// A small register FIFO of classified points so each side can stall alone.
// ----------------------------------------------------------------------------
module mbe_queue import mbe_pkg::*; #(
   parameter int DEPTH = MBE_QUEUE_DEPTH   // at least 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mbe_item_type  push_item,
   input  logic          pop,
   output mbe_item_type  head_item,
   output mbe_qstat_type stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbe_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/mbe_iter.sv -----
// ----------------------------------------------------------------------------
// mbe_iter: escape-time iteration engine
// Pops classified points and runs z = z*z + c; each iteration passes B_TEST,
// which forms the three products, then B_UPD for the escape test and the update.
// ----------------------------------------------------------------------------
module mbe_iter import mbe_pkg::*; #(
   parameter int FRAC_BITS = MBE_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mbe_item_type           q_item,
   input  mbe_qstat_type          q_stat,
   output logic                   q_pop,
   input  logic [MBE_CNT_W-1:0]   iteration_limit,
   input  logic                   cycle_check_enable,
   output logic                   rsp_valid,
   output logic [MBE_CNT_W-1:0]   rsp_iteration_count,
   output logic [MBE_CAUSE_W-1:0] rsp_end_cause
);

   // z needs room for a shifted square of up to 8 plus a coordinate.
   localparam int ZW       = ((FRAC_BITS + 4 > MBE_IN_W) ? FRAC_BITS + 4 : MBE_IN_W) + 2;
   localparam int OW       = FRAC_BITS + 3;   // multiplier operand once |z| <= 2
   localparam int PW       = 2 * OW;
   localparam int PERIOD_W = $clog2(2 * MBE_CHECK_CAP);

   localparam logic signed [ZW-1:0] C_TWO   = ZW'(2) <<< FRAC_BITS;
   localparam logic [PW:0]          C_FOUR2 = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_TEST = 3'b010,
      B_UPD  = 3'b100
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic signed [ZW-1:0]      cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0]      zr_ff, zr_in, zi_ff, zi_in;
   logic signed [ZW-1:0]      sr_ff, sr_in, si_ff, si_in;
   logic [MBE_CNT_W-1:0]      iter_ff, iter_in;
   logic [PERIOD_W-1:0]       period_ff, period_in, interval_ff, interval_in;
   logic                      big_ff, big_in;
   logic signed [PW-1:0]      zr2_ff, zr2_in, zi2_ff, zi2_in, zrzi_ff, zrzi_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [MBE_CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   mbe_cause_type             rsp_cause_ff, rsp_cause_in;

   logic signed [OW-1:0]      op_r, op_i;
   logic                      big;
   logic [PW:0]               mag;
   logic signed [PW-1:0]      diff, diff_sh, cross_sh;
   logic signed [ZW-1:0]      nr, ni;
   logic [PERIOD_W-1:0]       period_next;

   assign op_r = zr_ff[OW-1:0];
   assign op_i = zi_ff[OW-1:0];
   assign big  = (zr_ff > C_TWO) || (zr_ff < -C_TWO) ||
                 (zi_ff > C_TWO) || (zi_ff < -C_TWO);

   assign mag      = {1'b0, $unsigned(zr2_ff)} + {1'b0, $unsigned(zi2_ff)};
   assign diff     = zr2_ff - zi2_ff;
   assign diff_sh  = diff >>> FRAC_BITS;
   assign cross_sh = zrzi_ff >>> (FRAC_BITS - 1);
   assign nr       = $signed(diff_sh[ZW-1:0]) + cr_ff;
   assign ni       = $signed(cross_sh[ZW-1:0]) + ci_ff;

   assign period_next = period_ff + 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_end_cause       = rsp_cause_ff;

   always_comb begin
      state_in     = state_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      iter_in      = iter_ff;
      period_in    = period_ff;
      interval_in  = interval_ff;
      big_in       = big_ff;
      zr2_in       = zr2_ff;
      zi2_in       = zi2_ff;
      zrzi_in      = zrzi_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_cause_in = rsp_cause_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               if (q_item.interior) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = iteration_limit;
                  rsp_cause_in = CAUSE_INTERIOR;
               end else begin
                  cr_in       = {{(ZW-MBE_IN_W){q_item.point_real[MBE_IN_W-1]}},
                                 q_item.point_real};
                  ci_in       = {{(ZW-MBE_IN_W){q_item.point_imag[MBE_IN_W-1]}},
                                 q_item.point_imag};
                  zr_in       = '0;
                  zi_in       = '0;
                  sr_in       = '0;
                  si_in       = '0;
                  iter_in     = '0;
                  period_in   = '0;
                  interval_in = PERIOD_W'(MBE_CHECK_START);
                  state_in    = B_TEST;
               end
            end
         end
         B_TEST: begin
            if (iter_ff >= iteration_limit) begin
               // Limit reached: the last z is not tested for escape.
               rsp_valid_in = 1'b1;
               rsp_count_in = iter_ff;
               rsp_cause_in = CAUSE_LIMIT;
               state_in     = B_IDLE;
            end else begin
               big_in   = big;
               zr2_in   = op_r * op_r;
               zi2_in   = op_i * op_i;
               zrzi_in  = op_r * op_i;
               state_in = B_UPD;
            end
         end
         B_UPD: begin
            if (big_ff || (mag > C_FOUR2)) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = iter_ff;
               rsp_cause_in = CAUSE_ESCAPED;
               state_in     = B_IDLE;
            end else begin
               zr_in    = nr;
               zi_in    = ni;
               iter_in  = iter_ff + 1'b1;
               state_in = B_TEST;
               if (cycle_check_enable) begin
                  period_in = period_next;
                  if (period_next >= interval_ff) begin
                     if ((nr == sr_ff) && (ni == si_ff)) begin
                        rsp_valid_in = 1'b1;
                        rsp_count_in = iteration_limit;
                        rsp_cause_in = CAUSE_PERIODIC;
                        state_in     = B_IDLE;
                     end else begin
                        sr_in     = nr;
                        si_in     = ni;
                        period_in = '0;
                        if (interval_ff < PERIOD_W'(MBE_CHECK_CAP)) begin
                           interval_in = interval_ff << 1;
                        end
                     end
                  end
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      sr_ff        <= sr_in;
      si_ff        <= si_in;
      iter_ff      <= iter_in;
      period_ff    <= period_in;
      interval_ff  <= interval_in;
      big_ff       <= big_in;
      zr2_ff       <= zr2_in;
      zi2_ff       <= zi2_in;
      zrzi_ff      <= zrzi_in;
      rsp_count_ff <= rsp_count_in;
      rsp_cause_ff <= rsp_cause_in;
   end

endmodule

// ----- verif/mandelbrot_escape_time_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_test: self-checking bench of the escape-time unit
// Drives points through the command channel, and writes the iteration limit
// and cycle check registers over the register port between phases. Every
// result beat is checked against a built-in predictor of the block. Directed
// points come first, then random points in three idling phases.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_test;
   import mbe_pkg::*;

   // Fixed-point constants of the predictor, at FRAC or 2*FRAC fraction bits.
   localparam int    FRAC    = MBE_FRAC_BITS;
   localparam int    ONE_Q   = 1 << FRAC;                    // 1.0 as a 32-bit input
   localparam longint ONE_L  = longint'(1) << FRAC;
   localparam longint TWO_L  = longint'(2) << FRAC;
   localparam longint FOUR_SQ = longint'(1) << (2 * FRAC + 2); // 4.0 at 2*FRAC bits
   localparam longint BULB_SQ = longint'(1) << (2 * FRAC - 4); // 1/16 at 2*FRAC bits

   // The slowest point runs 65535 iterations, a stretch that can pass without any
   // beat. The limit allows several times that.
   localparam int STALL_LIMIT = 500000;

   typedef struct {
      logic [MBE_CNT_W-1:0] count;
      mbe_cause_type        cause;
   } escape_result_type;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       start          = 1'b0;
   logic                       busy;
   logic signed [MBE_IN_W-1:0] req_point_real = '0;
   logic signed [MBE_IN_W-1:0] req_point_imag = '0;
   logic                       rsp_valid;
   logic [MBE_CNT_W-1:0]       rsp_iteration_count;
   logic [MBE_CAUSE_W-1:0]     rsp_end_cause;
   logic                       psel           = 1'b0;
   logic                       penable        = 1'b0;
   logic                       pwrite         = 1'b0;
   logic [MBE_ADDR_W-1:0]      paddr          = '0;
   logic [MBE_DATA_W-1:0]      pwdata         = '0;
   logic [MBE_DATA_W-1:0]      prdata;
   logic                       pready;

   // The predictor's own copy of the two registers.
   logic [MBE_CNT_W-1:0] model_limit = MBE_LIMIT_RESET;
   logic                 model_check = MBE_CHECK_RESET;

   escape_result_type pending_escapes[$];
   int                mismatch_count  = 0;
   int                sender_idle_pct = 0;
   int                stall_cycles    = 0;

   mandelbrot_escape_time DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_point_real      (req_point_real),
      .req_point_imag      (req_point_imag),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_end_cause       (rsp_end_cause),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the escape-time result of one point under the current register
   // copy. Its fixed-point values are held at 64 bits, which is wide enough that no
   // intermediate product can wrap.
   function automatic escape_result_type predict_escape(input logic [31:0] re_bits,
                                                        input logic [31:0] im_bits);
      longint            cr, ci, zr, zi, saved_r, saved_i, nr, ni;
      longint            x, y2, q, bx;
      int unsigned       iter, period, interval, lim;
      logic              interior;
      escape_result_type res;
      cr = $signed(re_bits);
      ci = $signed(im_bits);
      lim = model_limit;

      // The cardioid and bulb tests only apply inside a box around both.
      interior = 1'b0;
      if (cr >= -TWO_L && cr <= ONE_L && ci <= ONE_L && ci >= -ONE_L) begin
         x  = cr - (ONE_L >>> 2);
         y2 = ci * ci;
         q  = (x * x + y2) >>> FRAC;
         bx = cr + ONE_L;
         interior = (q * (q + x) <= (y2 >>> 2)) || (bx * bx + y2 <= BULB_SQ);
      end
      if (interior) begin
         res.count = model_limit;
         res.cause = CAUSE_INTERIOR;
         return res;
      end

      zr = 0;
      zi = 0;
      saved_r = 0;
      saved_i = 0;
      iter = 0;
      period = 0;
      interval = MBE_CHECK_START;
      res.cause = CAUSE_LIMIT;
      while (iter < lim) begin
         // The escape test runs before each step, so the z of the last step
         // is never tested once the limit is hit.
         if (zr > TWO_L || zr < -TWO_L || zi > TWO_L || zi < -TWO_L ||
             zr * zr + zi * zi > FOUR_SQ) begin
            res.cause = CAUSE_ESCAPED;
            break;
         end
         nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
         ni = ((zr * zi) >>> (FRAC - 1)) + ci;
         zr = nr;
         zi = ni;
         iter++;
         if (model_check) begin
            period++;
            if (period >= interval) begin
               if (zr == saved_r && zi == saved_i) begin
                  iter = lim;
                  res.cause = CAUSE_PERIODIC;
                  break;
               end
               saved_r = zr;
               saved_i = zi;
               period = 0;
               if (interval < MBE_CHECK_CAP) interval *= 2;
            end
         end
      end
      res.count = iter[MBE_CNT_W-1:0];
      return res;
   endfunction

   // Sends one point. Start stays high after the beat so that back-to-back
   // points follow with no gap; a gap lowers it first.
   task automatic send_point(input int re, input int im);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_point_real <= re;
      req_point_imag <= im;
      do @(posedge clock); while (busy);
      pending_escapes.push_back(predict_escape(re, im));
   endtask

   // Holds the sender off until every outstanding result has arrived.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_escapes.size() != 0) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase that ends at the
   // edge where pready is seen high. Upper data bits are random; the block
   // keeps only the register's width.
   task automatic write_register(input mbe_reg_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input mbe_reg_type idx, input logic [31:0] want);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== want) begin
         $display("%0t ns: register %0d read mismatch, expected %0h actual %0h",
                  $time, idx, want, got);
         mismatch_count++;
      end
   endtask

   // Registers only change while the block is idle, so the predictor's copy
   // always matches what the block used for each point.
   task automatic set_config(input logic [15:0] lim, input logic check_on);
      drain_results();
      write_register(REG_LIMIT, {16'($urandom), lim});
      write_register(REG_CHECK, {31'($urandom), check_on});
      model_limit = lim;
      model_check = check_on;
      check_register(REG_LIMIT, {16'h0, lim});
      check_register(REG_CHECK, {31'h0, check_on});
   endtask

   task automatic test_reset_values();
      check_register(REG_LIMIT, {16'h0, MBE_LIMIT_RESET});
      check_register(REG_CHECK, {31'h0, MBE_CHECK_RESET});
   endtask

   // Region tests and their boundaries under the reset settings.
   task automatic test_known_regions();
      set_config(MBE_LIMIT_RESET, MBE_CHECK_RESET);
      send_point(0, 0);                           // center of the cardioid
      send_point(-ONE_Q, 0);                      // center of the bulb
      send_point(ONE_Q / 4, 0);                   // cusp, exactly on the edge
      send_point(ONE_Q / 4 + 1, 0);               // just outside the cusp, slow
      send_point(-ONE_Q - ONE_Q / 4, 0);          // left edge of the bulb
      send_point(-ONE_Q - ONE_Q / 4 - 1, 0);      // just left of the bulb
      send_point(-ONE_Q * 3 / 4, 0);              // neck between both regions
      send_point(-2 * ONE_Q, 0);                  // fixed point at 2: periodic
      send_point(-2 * ONE_Q - 1, 0);              // just outside the box
      send_point(ONE_Q, 0);                       // right edge of the box
      send_point(0, ONE_Q);                       // period-2 orbit
      send_point(0, -ONE_Q);
      send_point(ONE_Q * 3 / 10, 0);              // slow escape
   endtask

   // Limits of zero, one and the maximum, with points at the input extremes.
   task automatic test_limit_extremes();
      set_config(16'd0, 1'b1);
      send_point(0, 0);                           // interior, no iteration
      send_point(ONE_Q / 2, 0);                   // limit reached at once
      set_config(16'd1, 1'b1);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF);     // last z is not tested
      send_point(ONE_Q / 2, 0);
      set_config(16'hFFFF, 1'b1);
      send_point(32'h80000000, 32'h80000000);
      send_point(32'h80000000, 32'h7FFFFFFF);
      send_point(32'h7FFFFFFF, 32'h80000000);
      send_point(0, 0);
      send_point(0, ONE_Q);                       // caught by the cycle check
   endtask

   // The period-2 orbit of c = i repeats first at the second snapshot, on
   // step 60: a limit of 60 catches it, a limit of 59 does not.
   task automatic test_cycle_check();
      set_config(16'd100, 1'b0);
      send_point(0, ONE_Q);
      send_point(-2 * ONE_Q, 0);
      set_config(16'd60, 1'b1);
      send_point(0, ONE_Q);
      set_config(16'd59, 1'b1);
      send_point(0, ONE_Q);
   endtask

   // Random points. The settings change every 25 points. Most limits are
   // small so that points which never escape stay cheap.
   task automatic test_random_points(input int idle_pct, input int count);
      int re, im, pick, jitter;
      logic [15:0] lim;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            pick = $urandom_range(99);
            if (pick < 5)       lim = 16'd0;
            else if (pick < 10) lim = 16'd1;
            else if (pick < 50) lim = 16'($urandom_range(2, 40));
            else if (pick < 90) lim = 16'($urandom_range(41, 300));
            else                lim = MBE_LIMIT_RESET;
            set_config(lim, 1'($urandom_range(1)));
         end
         // Now and then the sender waits for the block to run dry.
         if ($urandom_range(99) < 3) drain_results();

         pick = $urandom_range(99);
         if (pick < 15) begin
            // Any bit pattern at all; nearly all of these escape at once.
            re = $urandom;
            im = $urandom;
         end else if (pick < 30) begin
            // Close to a notable value, on either side of it.
            jitter = $urandom_range(64) - 32;
            case ($urandom_range(5))
               0:       re = 0;
               1:       re = ONE_Q / 4;
               2:       re = -ONE_Q;
               3:       re = -2 * ONE_Q;
               4:       re = ONE_Q;
               default: re = -ONE_Q * 3 / 4;
            endcase
            re = re + jitter;
            im = ($urandom_range(1) ? ONE_Q : 0) * ($urandom_range(1) ? 1 : -1)
                 + int'($urandom_range(64)) - 32;
         end else begin
            // The usual view window, [-2.25, 0.75] by [-1.5, 1.5].
            re = int'($urandom_range(0, 3 * ONE_Q)) - 9 * (ONE_Q / 4);
            im = int'($urandom_range(0, 3 * ONE_Q)) - 3 * (ONE_Q / 2);
         end
         send_point(re, im);
      end
   endtask

   // Each result beat is taken at the edge that ends its cycle and checked
   // against the oldest prediction.
   always @(posedge clock) begin : check_results
      escape_result_type oldest;
      if (!reset && rsp_valid) begin
         if (pending_escapes.size() == 0) begin
            $display("%0t ns: unexpected result beat, count %0d cause %0d",
                     $time, rsp_iteration_count, rsp_end_cause);
            mismatch_count++;
         end else begin
            oldest = pending_escapes.pop_front();
            if (rsp_iteration_count !== oldest.count) begin
               $display("%0t ns: iteration count mismatch, expected %0d actual %0d",
                        $time, oldest.count, rsp_iteration_count);
               mismatch_count++;
            end
            if (rsp_end_cause !== oldest.cause) begin
               $display("%0t ns: end cause mismatch, expected %0d actual %0d",
                        $time, oldest.cause, rsp_end_cause);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any command or result beat restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: watchdog, no beat for %0d cycles", $time, stall_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      sender_idle_pct = 13;
      test_known_regions();
      test_limit_extremes();
      test_cycle_check();
      test_random_points(13, 150);
      test_random_points(53, 150);
      test_random_points(0, 150);

      // Wait for the last results, then a little longer so that a stray beat
      // from an interior point would still be seen.
      drain_results();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
